[rtl/kda_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kda_pkg
// Shared types and constants for the keypad debounce / auto-repeat front end.
// ----------------------------------------------------------------------------
package kda_pkg;

  localparam int RAW_W    = 4;   // raw button pins carried by one word
  localparam int LIMIT_W  = 8;
  localparam int DELAY_W  = 16;
  localparam int BEEP_W   = 8;
  localparam int CODE_W   = 3;
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 16;

  localparam logic [LIMIT_W-1:0] DEBOUNCE_LIMIT_RST = 8'd100;
  localparam logic [DELAY_W-1:0] REPEAT_DELAY_RST   = 16'd700;
  localparam logic [DELAY_W-1:0] REPEAT_PERIOD_RST  = 16'd10;
  localparam logic [BEEP_W-1:0]  BEEP_LENGTH_RST    = 8'd20;

  localparam logic [CODE_W-1:0]  KEY_CODE_BASE      = 3'd4;

  // configuration register indexes
  localparam logic [CFG_AW-1:0] REG_DEBOUNCE_LIMIT = 3'd0;
  localparam logic [CFG_AW-1:0] REG_REPEAT_DELAY   = 3'd1;
  localparam logic [CFG_AW-1:0] REG_REPEAT_PERIOD  = 3'd2;
  localparam logic [CFG_AW-1:0] REG_BEEP_LENGTH    = 3'd3;
  localparam logic [CFG_AW-1:0] REG_REPEAT_ENABLE  = 3'd4;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_READ = 1'b1
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [RAW_W-1:0] raw_buttons;
  } in_word_t;

  typedef struct packed {
    logic              key_ready;
    logic [CODE_W-1:0] key_code;
    logic              bell_level;
    logic              repeating;
  } out_word_t;

  typedef struct packed {
    logic [DELAY_W-1:0] repeat_delay;
    logic [DELAY_W-1:0] repeat_period;
    logic [BEEP_W-1:0]  beep_length;
    logic               repeat_enable;
  } cfg_regs_t;

endpackage

[rtl/keypad_debounce_autorepeat_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keypad_debounce_autorepeat_core
// Keypad front end: per-key debounce lanes, round-robin scan with scan-code
// latch, auto-repeat timing and beeper, on a 1 ms tick word.
//
//   port group   dir   handshake          word
//   in_*         in    in_valid/in_ready  kda_pkg::in_word_t
//   out_*        out   out_valid/out_ready kda_pkg::out_word_t
//   cfg_*        in    cfg_we             cfg_addr / cfg_wdata
//
// One word per cycle; its result word appears in the output register on the
// next cycle. The scan stage updates on each accepted word, the lanes only on
// tick words. in_ready drops only while a result sits in the output register
// and out_ready is low. rst_n is synchronous and resets all but out_data_r.
// ----------------------------------------------------------------------------
module keypad_debounce_autorepeat_core #(
  parameter int NUM_KEYS = 4
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  kda_pkg::in_word_t           in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output kda_pkg::out_word_t          out_data,
  input  logic                        cfg_we,
  input  logic [kda_pkg::CFG_AW-1:0]  cfg_addr,
  input  logic [kda_pkg::CFG_DW-1:0]  cfg_wdata
);

  logic [kda_pkg::LIMIT_W-1:0] limit_r;
  kda_pkg::cfg_regs_t          cfg_r;
  logic                        fire;
  logic                        tick_en;
  logic [NUM_KEYS-1:0]         level_nxt;
  kda_pkg::out_word_t          res_nxt;
  logic                        out_valid_r;
  kda_pkg::out_word_t          out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r             <= kda_pkg::DEBOUNCE_LIMIT_RST;
      cfg_r.repeat_delay  <= kda_pkg::REPEAT_DELAY_RST;
      cfg_r.repeat_period <= kda_pkg::REPEAT_PERIOD_RST;
      cfg_r.beep_length   <= kda_pkg::BEEP_LENGTH_RST;
      cfg_r.repeat_enable <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        kda_pkg::REG_DEBOUNCE_LIMIT: limit_r <= cfg_wdata[kda_pkg::LIMIT_W-1:0];
        kda_pkg::REG_REPEAT_DELAY:   cfg_r.repeat_delay  <= cfg_wdata;
        kda_pkg::REG_REPEAT_PERIOD:  cfg_r.repeat_period <= cfg_wdata;
        kda_pkg::REG_BEEP_LENGTH:    cfg_r.beep_length   <= cfg_wdata[kda_pkg::BEEP_W-1:0];
        kda_pkg::REG_REPEAT_ENABLE:  cfg_r.repeat_enable <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign in_ready = !out_valid_r || out_ready;
  assign fire     = in_valid && in_ready;
  assign tick_en  = fire && (in_data.op == kda_pkg::OP_TICK);

  for (genvar i = 0; i < NUM_KEYS; i++) begin : g_lane
    logic raw_bit;
    // pins past the raw field read as pressed
    if (i < kda_pkg::RAW_W) begin : g_pin
      assign raw_bit = in_data.raw_buttons[i];
    end else begin : g_nopin
      assign raw_bit = 1'b0;
    end

    kda_lane u_lane (
      .clk       (clk),
      .rst_n     (rst_n),
      .tick_en   (tick_en),
      .raw_bit   (raw_bit),
      .limit     (limit_r),
      .level_nxt (level_nxt[i])
    );
  end

  kda_scan #(
    .NUM_KEYS (NUM_KEYS)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .op        (in_data.op),
    .level_nxt (level_nxt),
    .cfg       (cfg_r),
    .res_nxt   (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[rtl/kda_lane.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kda_lane
// One button debouncer: saturating up/down integrator with hysteresis.
// ----------------------------------------------------------------------------
module kda_lane (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        tick_en,
  input  logic                        raw_bit,
  input  logic [kda_pkg::LIMIT_W-1:0] limit,
  output logic                        level_nxt
);

  logic [kda_pkg::LIMIT_W-1:0] integ_r;
  logic [kda_pkg::LIMIT_W-1:0] integ_nxt;
  logic                        level_r;

  always_comb begin
    integ_nxt = integ_r;
    level_nxt = level_r;
    if (raw_bit) begin
      if (integ_r < limit) begin
        integ_nxt = integ_r + 1'b1;
      end
      if (integ_nxt >= limit) begin
        level_nxt = 1'b1;
      end
    end else begin
      if (integ_r != '0) begin
        integ_nxt = integ_r - 1'b1;
      end
      if (integ_nxt == '0) begin
        level_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r <= kda_pkg::DEBOUNCE_LIMIT_RST;
      level_r <= 1'b1;
    end else if (tick_en) begin
      integ_r <= integ_nxt;
      level_r <= level_nxt;
    end
  end

endmodule

[rtl/kda_scan.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kda_scan
// Merge stage: round-robin key scan over the lane levels, scan-code latch,
// auto-repeat timer and beeper.
// ----------------------------------------------------------------------------
module kda_scan #(
  parameter int NUM_KEYS = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire,
  input  kda_pkg::op_t         op,
  input  logic [NUM_KEYS-1:0]  level_nxt,
  input  kda_pkg::cfg_regs_t   cfg,
  output kda_pkg::out_word_t   res_nxt
);

  localparam int SCAN_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam logic [SCAN_W-1:0] LAST_POS = SCAN_W'(NUM_KEYS - 1);

  logic [NUM_KEYS-1:0]          held_r, held_nxt;
  logic [SCAN_W-1:0]            scan_r, scan_nxt;
  logic [SCAN_W-1:0]            lat_r, lat_nxt;
  logic                         rdy_r, rdy_nxt;
  logic                         dly_run_r, dly_run_nxt;
  logic                         dly_done_r, dly_done_nxt;
  logic                         rep_r, rep_nxt;
  logic [kda_pkg::DELAY_W-1:0]  dly_cnt_r, dly_cnt_nxt;
  logic                         beep_run_r, beep_run_nxt;
  logic [kda_pkg::BEEP_W-1:0]   beep_cnt_r, beep_cnt_nxt;
  logic                         bell_r, bell_nxt;
  logic [kda_pkg::CODE_W-1:0]   code;

  always_comb begin
    held_nxt     = held_r;
    scan_nxt     = scan_r;
    lat_nxt      = lat_r;
    rdy_nxt      = rdy_r;
    dly_run_nxt  = dly_run_r;
    dly_done_nxt = dly_done_r;
    rep_nxt      = rep_r;
    dly_cnt_nxt  = dly_cnt_r;
    beep_run_nxt = beep_run_r;
    beep_cnt_nxt = beep_cnt_r;
    bell_nxt     = bell_r;
    code         = '0;

    if (op == kda_pkg::OP_READ) begin
      rdy_nxt = 1'b0;
      code    = kda_pkg::KEY_CODE_BASE - kda_pkg::CODE_W'(lat_r);
    end else begin
      if (dly_run_r) begin
        dly_cnt_nxt = dly_cnt_r - 1'b1;
        if (dly_cnt_nxt == '0) begin
          dly_done_nxt = 1'b1;
          dly_run_nxt  = 1'b0;
        end
      end

      if (beep_run_r) begin
        bell_nxt     = ~bell_r;
        beep_cnt_nxt = beep_cnt_r - 1'b1;
        if (beep_cnt_nxt == '0) begin
          bell_nxt     = 1'b1;
          beep_run_nxt = 1'b0;
        end
      end

      if (!level_nxt[scan_r]) begin
        if (!held_r[scan_r]) begin
          // new press
          if (!rdy_r) begin
            lat_nxt = scan_r;
            rdy_nxt = 1'b1;
          end
          bell_nxt     = 1'b0;
          beep_run_nxt = 1'b1;
          beep_cnt_nxt = cfg.beep_length;
          dly_run_nxt  = 1'b1;
          dly_cnt_nxt  = cfg.repeat_delay;
        end else if (dly_done_nxt) begin
          rep_nxt = 1'b1;
          if (!rdy_r && cfg.repeat_enable) begin
            lat_nxt = scan_r;
            rdy_nxt = 1'b1;
          end
          dly_done_nxt = 1'b0;
          dly_run_nxt  = 1'b1;
          dly_cnt_nxt  = cfg.repeat_period;
        end
        held_nxt[scan_r] = 1'b1;
      end else begin
        if (held_r[scan_r]) begin
          dly_run_nxt  = 1'b0;
          dly_done_nxt = 1'b0;
          rep_nxt      = 1'b0;
        end
        held_nxt[scan_r] = 1'b0;
      end

      scan_nxt = (scan_r == LAST_POS) ? '0 : scan_r + 1'b1;
    end

    res_nxt.key_ready  = rdy_nxt;
    res_nxt.key_code   = code;
    res_nxt.bell_level = bell_nxt;
    res_nxt.repeating  = rep_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r     <= '0;
      scan_r     <= '0;
      lat_r      <= '0;
      rdy_r      <= 1'b0;
      dly_run_r  <= 1'b0;
      dly_done_r <= 1'b0;
      rep_r      <= 1'b0;
      dly_cnt_r  <= '0;
      beep_run_r <= 1'b0;
      beep_cnt_r <= '0;
      bell_r     <= 1'b1;
    end else if (fire) begin
      held_r     <= held_nxt;
      scan_r     <= scan_nxt;
      lat_r      <= lat_nxt;
      rdy_r      <= rdy_nxt;
      dly_run_r  <= dly_run_nxt;
      dly_done_r <= dly_done_nxt;
      rep_r      <= rep_nxt;
      dly_cnt_r  <= dly_cnt_nxt;
      beep_run_r <= beep_run_nxt;
      beep_cnt_r <= beep_cnt_nxt;
      bell_r     <= bell_nxt;
    end
  end

endmodule
